[hw/rtl/ring_direction_to_motor_amplitudes_macros.svh]
// assertion helpers used by the asserting top module
`ifndef RING_DIRECTION_TO_MOTOR_AMPLITUDES_MACROS_SVH
`define RING_DIRECTION_TO_MOTOR_AMPLITUDES_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RDMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that implies a consequence at the next clock
`define RDMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rdma_pkg.sv]
package rdma_pkg;

    // field widths
    localparam int unsigned MAX_MOTORS = 8;
    localparam int unsigned DIR_W      = 32;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned SEL_W      = 8;
    localparam int unsigned AMP_W      = 7;
    localparam int unsigned CNT_W      = 4;
    // (spacing >> 7) + 1 never exceeds 2^25
    localparam int unsigned DIV_W      = DIR_W - AMP_W + 1;

    localparam logic [DIR_W-1:0] ALL_ONES    = '1;
    localparam logic [CNT_W-1:0] RESET_COUNT = 4'd4;

    // request codes
    localparam logic REQ_SET_DIRECTION = 1'b0;
    localparam logic REQ_STOP          = 1'b1;

    // ring spacing for a motor count already clamped to 1..8
    function automatic logic [DIR_W-1:0] spacing_for(input logic [CNT_W-1:0] count);
        logic [DIR_W-1:0] sp;
        case (count)
            4'd1:    sp = ALL_ONES / 32'd1;
            4'd2:    sp = ALL_ONES / 32'd2;
            4'd3:    sp = ALL_ONES / 32'd3;
            4'd4:    sp = ALL_ONES / 32'd4;
            4'd5:    sp = ALL_ONES / 32'd5;
            4'd6:    sp = ALL_ONES / 32'd6;
            4'd7:    sp = ALL_ONES / 32'd7;
            4'd8:    sp = ALL_ONES / 32'd8;
            default: sp = ALL_ONES;
        endcase
        return sp;
    endfunction

    // one motor issued into the amplitude pipeline
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
        logic             stop;
        logic [DIR_W-1:0] offset;
        logic [DIR_W-1:0] direction;
    } t_motor_item;

    // control that travels alongside the arithmetic
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
        logic             zero;
    } t_pipe_tag;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [AMP_W-1:0] amplitude;
        logic             last;
    } t_motor_result;

endpackage

[hw/rtl/rdma_if.sv]
// request channel
interface rdma_req_if import rdma_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [DIR_W-1:0] direction;

    modport source (output valid, output req_type, output direction, input ready);
    modport sink   (input valid, input req_type, input direction, output ready);
endinterface

// result channel
interface rdma_res_if import rdma_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] motor_index;
    logic [SEL_W-1:0] mux_select;
    logic [AMP_W-1:0] amplitude;
    logic             last;

    modport source (output valid, output motor_index, output mux_select,
                    output amplitude, output last, input ready);
    modport sink   (input valid, input motor_index, input mux_select,
                    input amplitude, input last, output ready);
endinterface

// motor count write channel
interface rdma_cfg_if import rdma_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ring_direction_to_motor_amplitudes.sv]
// path of a request: sequencer registers, difference, magnitude, numerator, seven divide steps, output register
// throughput: one result per cycle while results are taken; the next request is accepted as the final motor issues
// the amplitude pipeline (difference, magnitude, seven divide steps) moves one motor a cycle while it is not stalled
// reset: synchronous active low, clears all valid bits and sets motor_count to 4
// a result stall freezes the whole pipeline without losing or repeating a motor
`include "ring_direction_to_motor_amplitudes_macros.svh"

module ring_direction_to_motor_amplitudes import rdma_pkg::*; #(
    parameter int unsigned P_MAX_MOTORS = MAX_MOTORS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rdma_cfg_if.sink   i_cfg,
    rdma_req_if.sink   i_req,
    rdma_res_if.source o_res
);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(P_MAX_MOTORS);

    // configuration
    logic [CNT_W-1:0] r_motor_count;
    logic [DIR_W-1:0] r_spacing;
    logic [DIV_W-1:0] r_divisor;
    logic [CNT_W-1:0] n_motor_count;
    logic [DIR_W-1:0] n_spacing;

    // request sequencer
    logic             r_busy;
    logic             r_req_stop;
    logic [DIR_W-1:0] r_req_dir;
    logic [IDX_W-1:0] r_motor;
    logic [DIR_W-1:0] r_offset;
    logic             w_issue_last;
    logic             w_advance;
    logic             w_req_accept;
    t_motor_item      w_item;

    // output register
    logic             r_out_valid;
    t_motor_result    r_out;
    logic             w_pipe_valid;
    t_motor_result    w_pipe_result;

    // clamp the written count and look up its spacing
    always_comb begin
        n_motor_count = i_cfg.data;
        if (n_motor_count == '0) begin
            n_motor_count = CNT_W'(1);
        end
        if (n_motor_count > MAX_COUNT) begin
            n_motor_count = MAX_COUNT;
        end
        n_spacing = spacing_for(n_motor_count);
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= RESET_COUNT;
            r_spacing     <= spacing_for(RESET_COUNT);
            r_divisor     <= DIV_W'(spacing_for(RESET_COUNT) >> AMP_W) + DIV_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_motor_count <= n_motor_count;
            r_spacing     <= n_spacing;
            r_divisor     <= DIV_W'(n_spacing >> AMP_W) + DIV_W'(1);
        end
    end

    // pipeline moves whenever the output register is free or being emptied
    assign w_advance    = !r_out_valid || o_res.ready;
    assign w_issue_last = (CNT_W'(r_motor) + CNT_W'(1)) == r_motor_count;
    assign i_req.ready  = !r_busy || (w_advance && w_issue_last);
    assign w_req_accept = i_req.valid && i_req.ready;

    // walk the motors of the current request, one per cycle while the pipeline advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_req_accept) begin
            r_busy <= 1'b1;
        end else if (w_advance && w_issue_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_accept) begin
            r_req_stop <= i_req.req_type;
            r_req_dir  <= i_req.direction;
            r_motor    <= '0;
            r_offset   <= '0;
        end else if (w_advance && r_busy) begin
            r_motor  <= r_motor + IDX_W'(1);
            r_offset <= r_offset + r_spacing;
        end
    end

    assign w_item.index     = r_motor;
    assign w_item.last      = w_issue_last;
    assign w_item.stop      = r_req_stop;
    assign w_item.offset    = r_offset;
    assign w_item.direction = r_req_dir;

    rdma_amp_pipe u_amp_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (r_busy),
        .i_item    (w_item),
        .i_spacing (r_spacing),
        .i_divisor (r_divisor),
        .o_valid   (w_pipe_valid),
        .o_result  (w_pipe_result)
    );

    // result transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_pipe_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_pipe_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.motor_index = r_out.index;
    assign o_res.mux_select  = SEL_W'(1) << r_out.index;
    assign o_res.amplitude   = r_out.amplitude;
    assign o_res.last        = r_out.last;

    // checks
    `RDMA_ASSERT(a_count_range, i_clk, i_rst_n, r_motor_count != '0 && r_motor_count <= MAX_COUNT, "motor count out of range")
    `RDMA_ASSERT(a_motor_in_ring, i_clk, i_rst_n, !r_busy || CNT_W'(r_motor) < r_motor_count, "issued motor beyond ring")
    `RDMA_ASSERT(a_last_on_final, i_clk, i_rst_n, !r_out_valid || (r_out.last == ((CNT_W'(r_out.index) + CNT_W'(1)) == r_motor_count)), "last flag on wrong motor")
    `RDMA_ASSERT_NEXT(a_issue_done, i_clk, i_rst_n, r_busy && w_advance && w_issue_last && !w_req_accept, !r_busy, "sequencer kept running after final motor")

endmodule

[hw/rtl/rdma_amp_pipe.sv]
module rdma_amp_pipe import rdma_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_valid,
    input  t_motor_item      i_item,
    input  logic [DIR_W-1:0] i_spacing,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_valid,
    output t_motor_result    o_result
);

    // stage 1: wrapped difference
    logic             r_s1_valid;
    t_pipe_tag        r_s1_tag;
    logic [DIR_W-1:0] r_s1_diff;

    // stage 2: magnitude
    logic             r_s2_valid;
    t_pipe_tag        r_s2_tag;
    logic [DIR_W-1:0] r_s2_mag;

    // division stages, entry 0 holds the numerator before any quotient bit
    logic             r_dv_valid [0:AMP_W];
    t_pipe_tag        r_dv_tag   [0:AMP_W];
    logic [AMP_W-1:0] r_dv_quot  [0:AMP_W];
    logic [DIR_W-1:0] r_dv_rem   [0:AMP_W-1];

    logic [DIR_W:0]   w_shift [0:AMP_W-1];
    logic [DIR_W:0]   w_trial [0:AMP_W-1];
    logic [DIR_W-1:0] w_rem   [0:AMP_W-1];
    logic [AMP_W-1:0] w_quot  [0:AMP_W-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int g = 0; g <= AMP_W; g++) begin
                r_dv_valid[g] <= 1'b0;
            end
        end else if (i_advance) begin
            r_s1_valid    <= i_valid;
            r_s2_valid    <= r_s1_valid;
            r_dv_valid[0] <= r_s2_valid;
            for (int g = 0; g < AMP_W; g++) begin
                r_dv_valid[g+1] <= r_dv_valid[g];
            end
        end
    end

    // front stages: difference, magnitude, range check and numerator
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_tag.index <= i_item.index;
            r_s1_tag.last  <= i_item.last;
            r_s1_tag.zero  <= (i_item.stop == REQ_STOP);
            r_s1_diff      <= i_item.offset - i_item.direction;

            r_s2_tag <= r_s1_tag;
            r_s2_mag <= r_s1_diff[DIR_W-1] ? (DIR_W'(0) - r_s1_diff) : r_s1_diff;

            r_dv_tag[0].index <= r_s2_tag.index;
            r_dv_tag[0].last  <= r_s2_tag.last;
            r_dv_tag[0].zero  <= r_s2_tag.zero || (r_s2_mag > i_spacing);
            r_dv_rem[0]       <= i_spacing - r_s2_mag;
            r_dv_quot[0]      <= '0;
        end
    end

    // one restoring quotient bit per stage, most significant first
    always_comb begin
        for (int g = 0; g < AMP_W; g++) begin
            w_shift[g] = (DIR_W+1)'(i_divisor) << (AMP_W - 1 - g);
            w_trial[g] = {1'b0, r_dv_rem[g]} - w_shift[g];
            if (w_trial[g][DIR_W]) begin
                w_rem[g]  = r_dv_rem[g];
                w_quot[g] = r_dv_quot[g];
            end else begin
                w_rem[g]  = w_trial[g][DIR_W-1:0];
                w_quot[g] = r_dv_quot[g] | (AMP_W'(1) << (AMP_W - 1 - g));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int g = 0; g < AMP_W; g++) begin
                r_dv_tag[g+1]  <= r_dv_tag[g];
                r_dv_quot[g+1] <= w_quot[g];
            end
            for (int g = 0; g < AMP_W - 1; g++) begin
                r_dv_rem[g+1] <= w_rem[g];
            end
        end
    end

    // result of the last stage
    assign o_valid            = r_dv_valid[AMP_W];
    assign o_result.index     = r_dv_tag[AMP_W].index;
    assign o_result.last      = r_dv_tag[AMP_W].last;
    assign o_result.amplitude = r_dv_tag[AMP_W].zero ? '0 : r_dv_quot[AMP_W];

endmodule

[dv/tb_top.sv]
module tb_top;
    import rdma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TYPED_W         = MAX_MOTORS * AMP_W;
    localparam int          AMP_SHIFT       = 7;
    localparam int          RESET_CYCLES    = 12;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          N_PHASES        = 8;
    localparam int          ITEMS_PER_PHASE = 46;
    localparam int          HOLD_PHASE      = 1;
    localparam int          STEADY_PHASE    = 5;
    localparam int          N_DIRECTED      = 17;
    localparam logic [31:0] HALF_TURN       = 32'h8000_0000;

    typedef enum logic {
        ROW_REQUEST,
        ROW_COUNT_WRITE
    } t_row_kind;

    // one line of the directed sequence
    typedef struct packed {
        t_row_kind          kind;
        logic [CNT_W-1:0]   cfg_data;
        logic               req_code;
        logic [DIR_W-1:0]   direction;
        logic               typed;
        logic [TYPED_W-1:0] typed_amps;
    } t_directed_row;

    // one motor amplitude as it should leave the block
    typedef struct {
        logic [IDX_W-1:0] motor;
        logic [SEL_W-1:0] sel;
        logic [AMP_W-1:0] amp;
        logic             last;
    } t_motor_amp;

    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        // reset count of four
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h0000_0000, 1'b1, TYPED_W'(127)},
        '{ROW_REQUEST, 4'd0, REQ_STOP,          32'hFFFF_FFFF, 1'b1, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'hFFFF_FFFF, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h8000_0000, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h3FFF_FFFF, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h1FFF_FFFF, 1'b0, TYPED_W'(0)},
        // zero count is taken as a single motor
        '{ROW_COUNT_WRITE, 4'd0, REQ_SET_DIRECTION, 32'h0, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h0000_0000, 1'b1, TYPED_W'(127)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h8000_0000, 1'b1, TYPED_W'(63)},
        '{ROW_REQUEST, 4'd0, REQ_STOP,          32'h1234_5678, 1'b1, TYPED_W'(0)},
        // oversized count saturates at eight motors
        '{ROW_COUNT_WRITE, 4'd15, REQ_SET_DIRECTION, 32'h0, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h0000_0000, 1'b1, TYPED_W'(127)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h5555_5555, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'h7FFF_FFFF, 1'b0, TYPED_W'(0)},
        '{ROW_COUNT_WRITE, 4'd3, REQ_SET_DIRECTION, 32'h0, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_SET_DIRECTION, 32'hAAAA_AAAA, 1'b0, TYPED_W'(0)},
        '{ROW_REQUEST, 4'd0, REQ_STOP,          32'h0000_0000, 1'b1, TYPED_W'(0)}
    };

    localparam logic [CNT_W-1:0] PHASE_COUNTS [4] = '{4'd1, 4'd8, 4'd2, 4'd11};

    logic clk;
    logic rst_n;

    rdma_cfg_if cfg_ch ();
    rdma_req_if req_ch ();
    rdma_res_if res_ch ();

    ring_direction_to_motor_amplitudes uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // predictor copy of the ring set-up
    logic [CNT_W-1:0] ring_count;
    logic [DIR_W-1:0] ring_spacing;

    t_motor_amp motor_amps_due [$];
    int         mismatches    = 0;
    int         hold_requests = 0;
    // request valid currently held high by the sender
    bit         req_offered   = 1'b0;

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // amplitude of one motor for a direction, given the ring spacing
    function automatic logic [AMP_W-1:0] ring_amplitude(input logic [DIR_W-1:0] offset,
                                                        input logic [DIR_W-1:0] direction,
                                                        input logic [DIR_W-1:0] spacing);
        logic [DIR_W-1:0] diff;
        logic [DIR_W-1:0] mag;
        logic [DIR_W-1:0] quot;
        diff = offset - direction;
        mag  = diff[DIR_W-1] ? (~diff + 1'b1) : diff;
        if (mag > spacing) return '0;
        quot = (spacing - mag) / ((spacing >> AMP_SHIFT) + 32'd1);
        return quot[AMP_W-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // directions clustered round the motor seats, plus plain random ones
    function automatic logic [DIR_W-1:0] pick_direction();
        logic [DIR_W-1:0] seat;
        logic [DIR_W-1:0] spread;
        int unsigned      pick;
        seat   = DIR_W'($urandom_range(0, ring_count - 1)) * ring_spacing;
        spread = DIR_W'($urandom) % ring_spacing;
        pick   = $urandom_range(0, 9);
        if (pick < 3) return DIR_W'($urandom);
        if (pick < 7) return seat + (spread << 1) - ring_spacing;
        if (pick == 7) return seat + DIR_W'($urandom_range(0, 255)) - DIR_W'(128);
        if (pick == 8) return seat;
        return seat + HALF_TURN;
    endfunction

    // offer one request and queue its motor amplitudes once it is taken
    task automatic offer_request(input logic               req_code,
                                 input logic [DIR_W-1:0]   direction,
                                 input logic               typed,
                                 input logic [TYPED_W-1:0] typed_amps);
        t_motor_amp m;
        req_offered       = 1'b1;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= req_code;
        req_ch.direction <= direction;
        do @(posedge clk); while (!req_ch.ready);
        for (int i = 0; i < ring_count; i++) begin
            m.motor = IDX_W'(i);
            m.sel   = SEL_W'(1) << i;
            m.last  = (i == ring_count - 1);
            if (typed)
                m.amp = typed_amps[i*AMP_W +: AMP_W];
            else if (req_code == REQ_STOP)
                m.amp = '0;
            else
                m.amp = ring_amplitude(DIR_W'(i) * ring_spacing, direction, ring_spacing);
            motor_amps_due.push_back(m);
        end
    endtask

    // drop the request valid once, if it is still up
    task automatic stop_sender();
        if (req_offered) begin
            req_offered   = 1'b0;
            req_ch.valid <= 1'b0;
        end
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            stop_sender();
            repeat (cycles) @(posedge clk);
        end
    endtask

    // wait for every queued amplitude, then let the pipeline settle
    task automatic drain_motors();
        while (motor_amps_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // motor count write, clamped as the block does
    task automatic write_motor_count(input logic [CNT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (data == '0)
            ring_count = CNT_W'(1);
        else if (data > MAX_MOTORS)
            ring_count = CNT_W'(MAX_MOTORS);
        else
            ring_count = data;
        ring_spacing = ALL_ONES / DIR_W'(ring_count);
    endtask

    // result side: random stalls, long ready runs, and the requested long hold
    initial begin : result_sink
        int run_left;
        int stall_left;
        int holds_done;
        res_ch.ready = 1'b0;
        run_left     = 0;
        stall_left   = 0;
        holds_done   = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                run_left   = 0;
                stall_left = HOLD_CYCLES;
            end else if (run_left == 0 && stall_left == 0) begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 12);
                stall_left = pick_gap();
            end
            if (run_left > 0) begin
                run_left--;
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
        end
    end

    // compare every result transaction with the oldest queued amplitude
    always @(posedge clk) begin : result_check
        t_motor_amp want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (motor_amps_due.size() == 0) begin
                $error("unexpected result: motor_index %0d amplitude %0d",
                       res_ch.motor_index, res_ch.amplitude);
                mismatches++;
            end else begin
                want = motor_amps_due.pop_front();
                if (res_ch.motor_index !== want.motor) begin
                    $error("motor_index: expected %0d, got %0d", want.motor, res_ch.motor_index);
                    mismatches++;
                end
                if (res_ch.mux_select !== want.sel) begin
                    $error("mux_select: expected 0x%02h, got 0x%02h", want.sel, res_ch.mux_select);
                    mismatches++;
                end
                if (res_ch.amplitude !== want.amp) begin
                    $error("amplitude: expected %0d, got %0d (motor %0d)",
                           want.amp, res_ch.amplitude, want.motor);
                    mismatches++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b (motor %0d)",
                           want.last, res_ch.last, want.motor);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_directed_row row;
        logic [CNT_W-1:0] count_data;
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_SET_DIRECTION;
        req_ch.direction = '0;
        ring_count       = RESET_COUNT;
        ring_spacing     = ALL_ONES / DIR_W'(RESET_COUNT);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed sequence
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_COUNT_WRITE) begin
                stop_sender();
                drain_motors();
                write_motor_count(row.cfg_data);
            end else begin
                offer_request(row.req_code, row.direction, row.typed, row.typed_amps);
                idle_sender(pick_gap());
            end
        end

        // random phases, each at its own motor count
        for (int phase = 0; phase < N_PHASES; phase++) begin
            stop_sender();
            drain_motors();
            count_data = (phase < 4) ? PHASE_COUNTS[phase] : CNT_W'($urandom_range(0, 15));
            write_motor_count(count_data);
            // result side holds off while requests keep coming back to back
            if (phase == HOLD_PHASE) hold_requests <= hold_requests + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_request(($urandom_range(0, 9) == 0) ? REQ_STOP : REQ_SET_DIRECTION,
                              pick_direction(), 1'b0, '0);
                if (phase != HOLD_PHASE && phase != STEADY_PHASE) idle_sender(pick_gap());
            end
        end

        stop_sender();
        drain_motors();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // overall time limit
    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
